/* hdl/pmct_pkg.sv */
// shared types and constants for the ps/2 mouse cursor tracker
// no dependencies; used by every module of the block except pmct_fifo
`default_nettype none

package pmct_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_ENABLE      = 2'd0;
  localparam logic [1:0] REG_DISP_WIDTH  = 2'd1;
  localparam logic [1:0] REG_DISP_HEIGHT = 2'd2;

  // configuration widths and reset values
  localparam int          SIZE_BITS    = 13;
  localparam logic [12:0] WIDTH_RESET  = 13'd1024;
  localparam logic [12:0] HEIGHT_RESET = 13'd768;

  // header byte masks
  localparam logic [7:0] HDR_SYNC     = 8'h08;
  localparam logic [7:0] HDR_OVERFLOW = 8'hC0;
  localparam logic [7:0] HDR_BUTTONS  = 8'h07;

  // packet position in the byte stream
  typedef enum logic [2:0] {
    ST_HEADER = 3'b001,
    ST_XDELTA = 3'b010,
    ST_YDELTA = 3'b100
  } byte_state_t;

  // decoded packet handed from the assembler to the cursor unit
  typedef struct packed {
    logic [2:0] buttons;
    logic [7:0] dx;
    logic [7:0] dy;
  } packet_t;

endpackage

`default_nettype wire

/* hdl/pmct_fifo.sv */
// small register fifo used between the stages of the tracker
// no package dependency; DEPTH must be a power of two of at least two
`default_nettype none

module pmct_fifo #(
  parameter int WIDTH = 19,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             rd,
  output logic      [WIDTH-1:0] rdata,
  output logic                  full,
  output logic                  empty
);

  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wptr;
  logic [AW-1:0]    rptr;
  logic [AW:0]      count;
  logic             do_wr;
  logic             do_rd;

  assign full  = (count == (AW+1)'(DEPTH));
  assign empty = (count == '0);
  assign do_wr = wr & ~full;
  assign do_rd = rd & ~empty;
  assign rdata = mem[rptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr] <= wdata;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= wptr + 1'b1;
      end
      if (do_rd) begin
        rptr <= rptr + 1'b1;
      end
      unique case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

/* hdl/pmct_front.sv */
// packet assembler: takes mouse bytes, keeps header alignment, drops overflow packets
// depends on pmct_pkg for header masks, state codes and the packet type
`default_nettype none

module pmct_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              accept,
  input  wire logic [7:0]        rx_byte,
  input  wire logic              enable,
  output logic                   pkt_valid,
  output pmct_pkg::packet_t      pkt
);

  pmct_pkg::byte_state_t state;
  logic [7:0]            header_byte;
  logic [7:0]            x_delta_byte;
  logic                  take;

  assign take = accept & enable;

  // a complete packet without overflow bits goes to the queue
  always_comb begin
    pkt.buttons = header_byte[2:0] & pmct_pkg::HDR_BUTTONS[2:0];
    pkt.dx      = x_delta_byte;
    pkt.dy      = rx_byte;
    pkt_valid   = take && (state == pmct_pkg::ST_YDELTA)
                  && ((header_byte & pmct_pkg::HDR_OVERFLOW) == 8'h00);
  end

  // byte position tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= pmct_pkg::ST_HEADER;
      header_byte  <= '0;
      x_delta_byte <= '0;
    end else if (take) begin
      unique case (state)
        pmct_pkg::ST_HEADER: begin
          if ((rx_byte & pmct_pkg::HDR_SYNC) != 8'h00) begin
            header_byte <= rx_byte;
            state       <= pmct_pkg::ST_XDELTA;
          end
        end
        pmct_pkg::ST_XDELTA: begin
          x_delta_byte <= rx_byte;
          state        <= pmct_pkg::ST_YDELTA;
        end
        default: begin
          state <= pmct_pkg::ST_HEADER;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* hdl/pmct_back.sv */
// cursor unit: applies packet deltas, clamps each axis, tracks previous buttons
// depends on pmct_pkg for the packet type and reset sizes
`default_nettype none

module pmct_back #(
  parameter int COORD_BITS = 12
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        pkt_valid,
  input  wire pmct_pkg::packet_t           pkt,
  input  wire logic [12:0]                 disp_width,
  input  wire logic [12:0]                 disp_height,
  input  wire logic                        res_full,
  output logic                             pkt_pop,
  output logic                             res_wr,
  output logic [2*COORD_BITS+5:0]          res_data
);

  localparam int SW = COORD_BITS + 2;
  localparam int LW = (COORD_BITS > pmct_pkg::SIZE_BITS) ? COORD_BITS : pmct_pkg::SIZE_BITS;
  localparam logic [LW-1:0] COORD_MAX_EXT = LW'({COORD_BITS{1'b1}});

  logic [COORD_BITS-1:0] pos_x;
  logic [COORD_BITS-1:0] pos_y;
  logic [2:0]            last_buttons;
  logic [COORD_BITS-1:0] pos_x_next;
  logic [COORD_BITS-1:0] pos_y_next;
  logic [COORD_BITS-1:0] lim_x;
  logic [COORD_BITS-1:0] lim_y;
  logic signed [SW-1:0]  sum_x;
  logic signed [SW-1:0]  sum_y;

  // clamp limit for one axis: size minus one, zero for zero, saturated to range
  function automatic logic [COORD_BITS-1:0] axis_limit(input logic [12:0] size);
    logic [12:0]   lim;
    logic [LW-1:0] lim_ext;
    lim     = (size == 13'd0) ? 13'd0 : size - 13'd1;
    lim_ext = LW'(lim);
    if (lim_ext > COORD_MAX_EXT) begin
      axis_limit = '1;
    end else begin
      axis_limit = lim_ext[COORD_BITS-1:0];
    end
  endfunction

  // clamp a signed sum into [0, lim]
  function automatic logic [COORD_BITS-1:0] clamp(input logic signed [SW-1:0] v,
                                                  input logic [COORD_BITS-1:0] lim);
    if (v[SW-1]) begin
      clamp = '0;
    end else if (v[SW-2:0] > {1'b0, lim}) begin
      clamp = lim;
    end else begin
      clamp = v[COORD_BITS-1:0];
    end
  endfunction

  // new position
  always_comb begin
    lim_x      = axis_limit(disp_width);
    lim_y      = axis_limit(disp_height);
    sum_x      = $signed({2'b00, pos_x}) + SW'($signed(pkt.dx));
    sum_y      = $signed({2'b00, pos_y}) - SW'($signed(pkt.dy));
    pos_x_next = clamp(sum_x, lim_x);
    pos_y_next = clamp(sum_y, lim_y);
  end

  // one packet per cycle whenever the result queue has room
  assign pkt_pop  = pkt_valid & ~res_full;
  assign res_wr   = pkt_pop;
  assign res_data = {pos_x_next, pos_y_next, pkt.buttons, last_buttons};

  // cursor state
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x        <= COORD_BITS'(pmct_pkg::WIDTH_RESET >> 1);
      pos_y        <= COORD_BITS'(pmct_pkg::HEIGHT_RESET >> 1);
      last_buttons <= '0;
    end else if (pkt_pop) begin
      pos_x        <= pos_x_next;
      pos_y        <= pos_y_next;
      last_buttons <= pkt.buttons;
    end
  end

endmodule

`default_nettype wire

/* hdl/ps2_mouse_cursor_tracker_top.sv */
// ps/2 mouse cursor tracker: top level with configuration registers and queues
// depends on pmct_pkg, pmct_front, pmct_fifo and pmct_back
//
// Usage: raw mouse bytes enter through a queue-style port (push/full); a byte
// is taken at an edge with push high and full low. Every complete packet of
// three bytes with no overflow bit yields one result (cursor_x, cursor_y,
// buttons, old_buttons) on a queue-style output (empty/pop); a result is
// taken at an edge with pop high and empty low. Bytes taken while enable is
// zero are dropped, as are header candidates without bit 3 set.
// Throughput: one byte per cycle while full is low. The edge that takes the last
// byte of a packet writes the packet queue; the cursor unit then writes the
// result queue once it has room, and the result is visible after that write.
// Stalls: the cursor unit holds while the two-entry result queue is full;
// full rises when the two-entry packet queue between the assembler and the
// cursor unit fills, so a stalled receiver backs up to the byte input.
// Reset (rst, synchronous) clears both queues, disables the stream, sets the
// screen to 1024 x 768 and centers the cursor. Registers are written through
// wr_en / wr_index / wr_data; the user must do so only while the block is idle, unchecked.
`default_nettype none

module ps2_mouse_cursor_tracker_top #(
  parameter int COORD_BITS = 12
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  wr_en,
  input  wire logic [1:0]            wr_index,
  input  wire logic [12:0]           wr_data,
  input  wire logic                  push,
  output logic                       full,
  input  wire logic [7:0]            rx_byte,
  output logic                       empty,
  input  wire logic                  pop,
  output logic [COORD_BITS-1:0]      cursor_x,
  output logic [COORD_BITS-1:0]      cursor_y,
  output logic [2:0]                 buttons,
  output logic [2:0]                 old_buttons
);

  localparam int PW = $bits(pmct_pkg::packet_t);
  localparam int RW = 2 * COORD_BITS + 6;

  logic                enable;
  logic [12:0]         disp_width;
  logic [12:0]         disp_height;
  logic                pkt_wr;
  pmct_pkg::packet_t   pkt_in;
  pmct_pkg::packet_t   pkt_out;
  logic                pkt_empty;
  logic                pkt_pop;
  logic                res_wr;
  logic                res_full;
  logic [RW-1:0]       res_in;
  logic [RW-1:0]       res_out;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      enable      <= 1'b0;
      disp_width  <= pmct_pkg::WIDTH_RESET;
      disp_height <= pmct_pkg::HEIGHT_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        pmct_pkg::REG_ENABLE:      enable      <= wr_data[0];
        pmct_pkg::REG_DISP_WIDTH:  disp_width  <= wr_data;
        pmct_pkg::REG_DISP_HEIGHT: disp_height <= wr_data;
        default: ;
      endcase
    end
  end

  // packet assembler
  pmct_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (push & ~full),
    .rx_byte   (rx_byte),
    .enable    (enable),
    .pkt_valid (pkt_wr),
    .pkt       (pkt_in)
  );

  // packet queue between assembler and cursor unit
  pmct_fifo #(
    .WIDTH (PW),
    .DEPTH (2)
  ) u_pkt_q (
    .clk   (clk),
    .rst   (rst),
    .wr    (pkt_wr),
    .wdata (pkt_in),
    .rd    (pkt_pop),
    .rdata (pkt_out),
    .full  (full),
    .empty (pkt_empty)
  );

  // cursor unit
  pmct_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .pkt_valid   (~pkt_empty),
    .pkt         (pkt_out),
    .disp_width  (disp_width),
    .disp_height (disp_height),
    .res_full    (res_full),
    .pkt_pop     (pkt_pop),
    .res_wr      (res_wr),
    .res_data    (res_in)
  );

  // result queue
  pmct_fifo #(
    .WIDTH (RW),
    .DEPTH (2)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .wr    (res_wr),
    .wdata (res_in),
    .rd    (pop),
    .rdata (res_out),
    .full  (res_full),
    .empty (empty)
  );

  // result fields
  assign cursor_x    = res_out[RW-1 -: COORD_BITS];
  assign cursor_y    = res_out[RW-COORD_BITS-1 -: COORD_BITS];
  assign buttons     = res_out[5:3];
  assign old_buttons = res_out[2:0];

endmodule

`default_nettype wire
